### hw/rtl/prf_pkg.sv
`default_nettype none
package prf_pkg;

	localparam int unsigned HeaderBytes   = 45;
	localparam int unsigned RecordBytes   = 59;
	localparam logic [30:0] MaxEntryReset = 31'd100000;
	localparam logic [7:0]  FileVersion   = 8'd1;

	typedef enum logic [2:0] {
		PH_HEADER = 3'b001,
		PH_RECORD = 3'b010,
		PH_DONE   = 3'b100
	} phase_t;

	typedef enum logic [1:0] {
		KIND_RECORD = 2'd0,
		KIND_REJECT = 2'd1,
		KIND_END    = 2'd2
	} kind_t;

	typedef struct packed {
		logic [1:0]         kind;
		logic               final_res;
		logic [31:0]        seen_time;
		logic [63:0]        service_bits;
		logic [63:0]        peer_addr_high;
		logic [63:0]        peer_addr_low;
		logic [15:0]        peer_port;
		logic [63:0]        origin_addr_high;
		logic [63:0]        origin_addr_low;
		logic signed [63:0] last_success_time;
		logic signed [31:0] attempt_count;
	} result_t;

endpackage
`default_nettype wire

### hw/rtl/prf_if.sv
`default_nettype none
interface prf_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       end_of_file;

	modport source (output valid, output data_byte, output end_of_file, input ready);
	modport sink   (input valid, input data_byte, input end_of_file, output ready);
endinterface

interface prf_out_if;
	logic               valid;
	logic               ready;
	logic [1:0]         kind;
	logic               final_res;
	logic [31:0]        seen_time;
	logic [63:0]        service_bits;
	logic [63:0]        peer_addr_high;
	logic [63:0]        peer_addr_low;
	logic [15:0]        peer_port;
	logic [63:0]        origin_addr_high;
	logic [63:0]        origin_addr_low;
	logic signed [63:0] last_success_time;
	logic signed [31:0] attempt_count;

	modport source (
		output valid, output kind, output final_res, output seen_time,
		output service_bits, output peer_addr_high, output peer_addr_low,
		output peer_port, output origin_addr_high, output origin_addr_low,
		output last_success_time, output attempt_count, input ready
	);
	modport sink (
		input valid, input kind, input final_res, input seen_time,
		input service_bits, input peer_addr_high, input peer_addr_low,
		input peer_port, input origin_addr_high, input origin_addr_low,
		input last_success_time, input attempt_count, output ready
	);
endinterface
`default_nettype wire

### hw/rtl/peer_record_file_parser_core.sv
// Peer record file parser.
// byte_ch carries the file one byte per transfer; a transfer with end_of_file
// set closes the file (its data byte is ignored) and returns the parser to the
// start of a header. result_ch carries one result per complete 59-byte record,
// plus a closing result (kind reject or end of list) where the file is bad,
// truncated or lists no records; final_res marks the result that closes the list.
// cfg_we/cfg_wdata load the largest record count the header may give; write it
// only while the block is idle.
// Throughput: one byte per cycle. Each byte is parsed in the cycle it is
// accepted and any result it causes sits in the result register, with
// result_ch.valid high, on the next cycle.
// byte_ch.ready stays high while the result register is empty or being drained;
// when the receiver stalls with a result pending, input stalls too.
// Reset clears the parse state and the result valid flag and loads the count
// limit with 100000.
`default_nettype none
module peer_record_file_parser_core (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         cfg_we,
	input  wire  [30:0] cfg_wdata,
	prf_in_if.sink      byte_ch,
	prf_out_if.source   result_ch
);
	import prf_pkg::*;

	logic [30:0] max_q;
	phase_t      phase_q, phase_d;
	logic [5:0]  pos_q, pos_d;
	logic [30:0] left_q, left_d;
	logic [31:0] count_q, count_d;
	logic [31:0] time_q, time_d;
	logic [63:0] service_q, service_d;
	logic [63:0] addr0_q, addr0_d, addr1_q, addr1_d;
	logic [15:0] port_q, port_d;
	logic [63:0] org0_q, org0_d, org1_q, org1_d;
	logic [63:0] success_q, success_d;
	logic [31:0] attempt_q, attempt_d;

	logic        out_vld_q;
	result_t     res_q, res_d;
	logic        emit;
	logic        accept;
	logic [7:0]  b;

	assign byte_ch.ready = !out_vld_q || result_ch.ready;
	assign accept        = byte_ch.valid && byte_ch.ready;
	assign b             = byte_ch.data_byte;

	always_comb begin
		phase_d   = phase_q;
		pos_d     = pos_q;
		left_d    = left_q;
		count_d   = count_q;
		time_d    = time_q;
		service_d = service_q;
		addr0_d   = addr0_q;
		addr1_d   = addr1_q;
		port_d    = port_q;
		org0_d    = org0_q;
		org1_d    = org1_q;
		success_d = success_q;
		attempt_d = attempt_q;
		emit      = 1'b0;
		res_d     = '0;

		if (accept) begin
			if (byte_ch.end_of_file) begin
				if (phase_q == PH_HEADER) begin
					emit = 1'b1;
					res_d.kind = KIND_REJECT;
					res_d.final_res = 1'b1;
				end else if (phase_q == PH_RECORD) begin
					emit = 1'b1;
					res_d.kind = KIND_END;
					res_d.final_res = 1'b1;
				end
				phase_d   = PH_HEADER;
				pos_d     = '0;
				left_d    = '0;
				count_d   = '0;
				time_d    = '0;
				service_d = '0;
				addr0_d   = '0;
				addr1_d   = '0;
				port_d    = '0;
				org0_d    = '0;
				org1_d    = '0;
				success_d = '0;
				attempt_d = '0;
			end else begin
				case (phase_q)
					PH_HEADER: begin
						if (pos_q == '0 && b != FileVersion) begin
							emit = 1'b1;
							res_d.kind = KIND_REJECT;
							res_d.final_res = 1'b1;
							phase_d = PH_DONE;
						end else begin
							if (pos_q inside {[6'd33:6'd36]})
								count_d = {b, count_q[31:8]};
							if (pos_q == 6'(HeaderBytes - 1)) begin
								pos_d = '0;
								if (count_d[31] || count_d > {1'b0, max_q}) begin
									emit = 1'b1;
									res_d.kind = KIND_REJECT;
									res_d.final_res = 1'b1;
									phase_d = PH_DONE;
								end else if (count_d == '0) begin
									emit = 1'b1;
									res_d.kind = KIND_END;
									res_d.final_res = 1'b1;
									phase_d = PH_DONE;
								end else begin
									left_d  = count_d[30:0];
									phase_d = PH_RECORD;
								end
							end else begin
								pos_d = pos_q + 6'd1;
							end
						end
					end
					PH_RECORD: begin
						if (pos_q == '0 && b != FileVersion) begin
							emit = 1'b1;
							res_d.kind = KIND_END;
							res_d.final_res = 1'b1;
							phase_d = PH_DONE;
						end else begin
							case (pos_q) inside
								[6'd1:6'd4]:   time_d    = {b, time_q[31:8]};
								[6'd5:6'd12]:  service_d = {b, service_q[63:8]};
								[6'd13:6'd20]: addr0_d   = {addr0_q[55:0], b};
								[6'd21:6'd28]: addr1_d   = {addr1_q[55:0], b};
								[6'd29:6'd30]: port_d    = {port_q[7:0], b};
								[6'd31:6'd38]: org0_d    = {org0_q[55:0], b};
								[6'd39:6'd46]: org1_d    = {org1_q[55:0], b};
								[6'd47:6'd54]: success_d = {b, success_q[63:8]};
								[6'd55:6'd58]: attempt_d = {b, attempt_q[31:8]};
								default: ;
							endcase
							if (pos_q == 6'(RecordBytes - 1)) begin
								pos_d  = '0;
								left_d = left_q - 31'd1;
								emit   = 1'b1;
								res_d.kind              = KIND_RECORD;
								res_d.final_res         = (left_d == '0);
								res_d.seen_time         = time_d;
								res_d.service_bits      = service_d;
								res_d.peer_addr_high    = addr0_d;
								res_d.peer_addr_low     = addr1_d;
								res_d.peer_port         = port_d;
								res_d.origin_addr_high  = org0_d;
								res_d.origin_addr_low   = org1_d;
								res_d.last_success_time = success_d;
								res_d.attempt_count     = attempt_d;
								if (left_d == '0)
									phase_d = PH_DONE;
							end else begin
								pos_d = pos_q + 6'd1;
							end
						end
					end
					PH_DONE: ;
					default: phase_d = PH_HEADER;
				endcase
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_q <= MaxEntryReset;
		end else if (cfg_we) begin
			max_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_HEADER;
			pos_q     <= '0;
			left_q    <= '0;
			count_q   <= '0;
			time_q    <= '0;
			service_q <= '0;
			addr0_q   <= '0;
			addr1_q   <= '0;
			port_q    <= '0;
			org0_q    <= '0;
			org1_q    <= '0;
			success_q <= '0;
			attempt_q <= '0;
		end else begin
			phase_q   <= phase_d;
			pos_q     <= pos_d;
			left_q    <= left_d;
			count_q   <= count_d;
			time_q    <= time_d;
			service_q <= service_d;
			addr0_q   <= addr0_d;
			addr1_q   <= addr1_d;
			port_q    <= port_d;
			org0_q    <= org0_d;
			org1_q    <= org1_d;
			success_q <= success_d;
			attempt_q <= attempt_d;
		end
	end

	// result register: refill whenever it is empty or being drained
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (byte_ch.ready) begin
			out_vld_q <= accept && emit;
		end
	end

	always_ff @(posedge clk) begin
		if (byte_ch.ready && accept && emit) begin
			res_q <= res_d;
		end
	end

	assign result_ch.valid             = out_vld_q;
	assign result_ch.kind              = res_q.kind;
	assign result_ch.final_res         = res_q.final_res;
	assign result_ch.seen_time         = res_q.seen_time;
	assign result_ch.service_bits      = res_q.service_bits;
	assign result_ch.peer_addr_high    = res_q.peer_addr_high;
	assign result_ch.peer_addr_low     = res_q.peer_addr_low;
	assign result_ch.peer_port         = res_q.peer_port;
	assign result_ch.origin_addr_high  = res_q.origin_addr_high;
	assign result_ch.origin_addr_low   = res_q.origin_addr_low;
	assign result_ch.last_success_time = res_q.last_success_time;
	assign result_ch.attempt_count     = res_q.attempt_count;

endmodule
`default_nettype wire

### hw/rtl/prf_checker.sv
`default_nettype none
module prf_checker (
	input wire         clk,
	input wire         arst_n,
	input wire         in_valid,
	input wire         in_ready,
	input wire         out_valid,
	input wire         out_ready,
	input wire  [1:0]  out_kind,
	input wire         out_final,
	input wire  [31:0] out_time,
	input wire  [31:0] out_attempt
);
	import prf_pkg::*;

	// a pending result holds until the transfer
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_kind) && $stable(out_time))
		else $error("result dropped or changed while stalled");

	// result valid only rises after an input transfer in the previous cycle
	a_cause: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_valid && in_ready))
		else $error("result without input transfer");

	// input never stalls while the result register is free
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("input stalled with empty result register");

	// reject and end-of-list results close the list and carry no record
	a_close: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_kind != KIND_RECORD |->
			out_final && out_time == '0 && out_attempt == '0)
		else $error("closing result malformed");

endmodule

bind peer_record_file_parser_core prf_checker u_prf_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (byte_ch.valid),
	.in_ready   (byte_ch.ready),
	.out_valid  (result_ch.valid),
	.out_ready  (result_ch.ready),
	.out_kind   (result_ch.kind),
	.out_final  (result_ch.final_res),
	.out_time   (result_ch.seen_time),
	.out_attempt(result_ch.attempt_count)
);
`default_nettype wire
